// ===== sv/fvrm_pkg.sv =====
// ----------------------------------------------------------------------------
// fvrm_pkg: shared types and constants for the force-to-rotor modulation block
// Register map codes, pipeline sideband structs and the CORDIC arctangent
// table in Q0.32 turns.
// ----------------------------------------------------------------------------
package fvrm_pkg;

    localparam int GROUP_COUNT   = 4;
    localparam int CORDIC_STAGES = 16;
    localparam int SQRT_STEPS    = 32;
    // CORDIC datapath width: 2^31 operands scaled by 2^24 plus gain growth
    localparam int CW            = 59;
    localparam int STAGE_W       = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

    localparam int ADDR_W        = 5;

    localparam logic [23:0] GAIN_RST    = 24'd65536;
    localparam logic [15:0] FLOOR_RST   = 16'd0;
    localparam logic [15:0] CEIL_RST    = 16'd65535;
    localparam logic [15:0] RATIO_RST   = 16'd256;
    localparam logic [15:0] LAG_RST     = 16'd0;

    localparam logic [14:0] FLAP_MAX    = 15'd16384;

    typedef enum logic [2:0] {
        REG_GAIN  = 3'd0,
        REG_FLOOR = 3'd1,
        REG_CEIL  = 3'd2,
        REG_RATIO = 3'd3,
        REG_LAG   = 3'd4
    } t_reg_idx;

    // sideband carried alongside the square-root chain
    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic [31:0]        afz;
        logic [15:0]        lift;
        logic               sat;
        logic               zero_lat;
        logic [1:0]         grp;
        logic               fin;
    } t_sq_side;

    // sideband carried alongside the CORDIC chain
    typedef struct packed {
        logic [15:0] side;
        logic [15:0] lift;
        logic        sat;
        logic        zero_lat;
        logic [1:0]  grp;
        logic        fin;
    } t_cd_side;

    // atan(2^-i) in Q0.32 turns
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            5'd31: v = 32'd0;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/fvrm_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// fvrm_sqrt_cell: one step of a digit-by-digit integer square root
// Tries one result bit per cell and hands remainder and root to the next.
// ----------------------------------------------------------------------------
module fvrm_sqrt_cell (
    input  logic        i_clk,
    input  logic [4:0]  i_step,
    input  logic [63:0] i_rem,
    input  logic [63:0] i_root,
    output logic [63:0] o_rem,
    output logic [63:0] o_root
);
    import fvrm_pkg::*;

    logic [63:0] r_rem, r_root;
    logic [63:0] n_rem, n_root;
    logic [63:0] w_bit, w_trial;
    logic [5:0]  w_sh;

    // trial bit for this step: 4^(31-step)
    assign w_sh    = 6'd62 - {i_step, 1'b0};
    assign w_bit   = 64'd1 << w_sh;
    assign w_trial = i_root + w_bit;

    always_comb begin
        if (i_rem >= w_trial) begin
            n_rem  = i_rem - w_trial;
            n_root = (i_root >> 1) + w_bit;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ===== sv/fvrm_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// fvrm_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates toward the x axis and accumulates the angle in Q0.32 turns.
// ----------------------------------------------------------------------------
module fvrm_cordic_cell (
    input  logic                               i_clk,
    input  logic [fvrm_pkg::STAGE_W-1:0]       i_stage,
    input  logic signed [fvrm_pkg::CW-1:0]     i_x,
    input  logic signed [fvrm_pkg::CW-1:0]     i_y,
    input  logic [31:0]                        i_z,
    output logic signed [fvrm_pkg::CW-1:0]     o_x,
    output logic signed [fvrm_pkg::CW-1:0]     o_y,
    output logic [31:0]                        o_z
);
    import fvrm_pkg::*;

    logic signed [CW-1:0] r_x, r_y, n_x, n_y;
    logic [31:0]          r_z, n_z;
    logic signed [CW-1:0] w_dx, w_dy;
    logic [31:0]          w_ang;

    assign w_dx  = i_y >>> i_stage;
    assign w_dy  = i_x >>> i_stage;
    assign w_ang = atan_turn(5'(i_stage));

    // direction follows the sign of y
    always_comb begin
        if (!i_y[CW-1]) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + w_ang;
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ===== sv/force_vector_to_rotor_modulation.sv =====
// ----------------------------------------------------------------------------
// force_vector_to_rotor_modulation: rotor group force to throttle and angles
// Fully pipelined: products, two square-root cell chains, two CORDIC chains.
// ----------------------------------------------------------------------------
// Usage:
//  A transaction is taken on the rising edge where start is high and busy is
//  low. busy is tied low: a new group may be issued on every clock.
//  Each transaction yields one result on the o_ result ports, valid for the
//  single cycle o_done is high. Results leave in issue order.
//  o_done rises once the transaction has passed through three registers of
//  input, product and clamp (the first loads at the accepting edge), 32
//  square-root cells, one register of gain product and CORDIC setup, the
//  CORDIC cells, and the output register, and the result is taken at the
//  edge after that.
//  Throughput is one transaction per clock.
//  The receiver cannot stall; nothing holds results back.
//  Configuration goes through the APB port (registers at 4*index) and should
//  be written only while no transaction is in flight. lag_angle is the
//  current motor_lag register.
//  Reset (i_rst_n low, synchronous) empties the pipeline and restores the
//  register defaults.
// ----------------------------------------------------------------------------
module force_vector_to_rotor_modulation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic signed [31:0]            i_force_x,
    input  logic signed [31:0]            i_force_y,
    input  logic signed [31:0]            i_force_z,
    input  logic [30:0]                   i_force_total,
    input  logic [1:0]                    i_group_number,
    input  logic                          i_final_group,
    // result channel
    output logic                          o_done,
    output logic [15:0]                   o_lift_throttle,
    output logic [15:0]                   o_side_throttle,
    output logic [14:0]                   o_flap_angle,
    output logic [15:0]                   o_phase_angle,
    output logic [15:0]                   o_lag_angle,
    output logic [1:0]                    o_group_echo,
    output logic                          o_final_echo,
    output logic                          o_flap_saturated,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fvrm_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import fvrm_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [23:0] r_gain;
    logic [15:0] r_floor, r_ceil, r_ratio, r_lag;
    logic [2:0]  w_idx;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RST;
            r_floor <= FLOOR_RST;
            r_ceil  <= CEIL_RST;
            r_ratio <= RATIO_RST;
            r_lag   <= LAG_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GAIN:  r_gain  <= pwdata[23:0];
                REG_FLOOR: r_floor <= pwdata[15:0];
                REG_CEIL:  r_ceil  <= pwdata[15:0];
                REG_RATIO: r_ratio <= pwdata[15:0];
                REG_LAG:   r_lag   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_GAIN:  prdata = {8'd0, r_gain};
            REG_FLOOR: prdata = {16'd0, r_floor};
            REG_CEIL:  prdata = {16'd0, r_ceil};
            REG_RATIO: prdata = {16'd0, r_ratio};
            REG_LAG:   prdata = {16'd0, r_lag};
            default:   prdata = 32'd0;
        endcase
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // stage 1: input capture
    // ------------------------------------------------------------------
    logic               r1_v;
    logic signed [31:0] r1_fx, r1_fy, r1_fz;
    logic [30:0]        r1_f;
    logic [1:0]         r1_grp;
    logic               r1_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= start && !busy;
    end

    always_ff @(posedge i_clk) begin
        r1_fx  <= i_force_x;
        r1_fy  <= i_force_y;
        r1_fz  <= i_force_z;
        r1_f   <= i_force_total;
        r1_grp <= i_group_number;
        r1_fin <= i_final_group;
    end

    // ------------------------------------------------------------------
    // stage 2: magnitudes and squares
    // ------------------------------------------------------------------
    logic [31:0] w_ax, w_ay, w_afz;
    logic [1:0]  w_grp;

    assign w_ax  = r1_fx[31] ? 32'(-r1_fx) : 32'(r1_fx);
    assign w_ay  = r1_fy[31] ? 32'(-r1_fy) : 32'(r1_fy);
    assign w_afz = r1_fz[31] ? 32'(-r1_fz) : 32'(r1_fz);
    assign w_grp = (int'(r1_grp) >= GROUP_COUNT) ? 2'(GROUP_COUNT - 1) : r1_grp;

    logic               r2_v;
    logic [63:0]        r2_ax2, r2_ay2, r2_f2, r2_afz2;
    logic [55:0]        r2_lp;
    logic signed [31:0] r2_fx, r2_fy;
    logic [31:0]        r2_afz;
    logic               r2_sat, r2_zero;
    logic [1:0]         r2_grp;
    logic               r2_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
    end

    always_ff @(posedge i_clk) begin
        r2_ax2  <= 64'(w_ax) * 64'(w_ax);
        r2_ay2  <= 64'(w_ay) * 64'(w_ay);
        r2_f2   <= 64'(r1_f) * 64'(r1_f);
        r2_afz2 <= 64'(w_afz) * 64'(w_afz);
        r2_lp   <= 56'(w_afz) * 56'(r_gain);
        r2_fx   <= r1_fx;
        r2_fy   <= r1_fy;
        r2_afz  <= w_afz;
        r2_sat  <= (r1_f == 31'd0) || (w_afz > 32'(r1_f));
        r2_zero <= (r1_fx == 32'sd0) && (r1_fy == 32'sd0);
        r2_grp  <= w_grp;
        r2_fin  <= r1_fin;
    end

    // ------------------------------------------------------------------
    // stage 3: radicands and lift clamp
    // ------------------------------------------------------------------
    logic [64:0] w_sum;
    logic [39:0] w_lraw;
    logic [15:0] w_lift;

    assign w_sum  = 65'(r2_ax2) + 65'(r2_ay2);
    assign w_lraw = r2_lp[55:16];

    // floor is checked before ceiling
    always_comb begin
        priority if (w_lraw < 40'(r_floor)) w_lift = r_floor;
        else if (w_lraw > 40'(r_ceil))      w_lift = r_ceil;
        else                                w_lift = w_lraw[15:0];
    end

    logic        r3_v;
    logic [63:0] r3_rad_s, r3_rad_f;
    t_sq_side    r3_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
    end

    always_ff @(posedge i_clk) begin
        r3_rad_s       <= w_sum[64:1];
        r3_rad_f       <= r2_sat ? 64'd0 : (r2_f2 - r2_afz2);
        r3_sb.fx       <= r2_fx;
        r3_sb.fy       <= r2_fy;
        r3_sb.afz      <= r2_afz;
        r3_sb.lift     <= w_lift;
        r3_sb.sat      <= r2_sat;
        r3_sb.zero_lat <= r2_zero;
        r3_sb.grp      <= r2_grp;
        r3_sb.fin      <= r2_fin;
    end

    // ------------------------------------------------------------------
    // square-root cell chains (lateral and flap radicands)
    // ------------------------------------------------------------------
    logic [63:0] w_srem [0:SQRT_STEPS];
    logic [63:0] w_sroot[0:SQRT_STEPS];
    logic [63:0] w_frem [0:SQRT_STEPS];
    logic [63:0] w_froot[0:SQRT_STEPS];
    logic        r_sq_v [0:SQRT_STEPS-1];
    t_sq_side    r_sq_sb[0:SQRT_STEPS-1];

    assign w_srem[0]  = r3_rad_s;
    assign w_sroot[0] = 64'd0;
    assign w_frem[0]  = r3_rad_f;
    assign w_froot[0] = 64'd0;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        fvrm_sqrt_cell u_lat (
            .i_clk  (i_clk),
            .i_step (5'(k)),
            .i_rem  (w_srem[k]),
            .i_root (w_sroot[k]),
            .o_rem  (w_srem[k+1]),
            .o_root (w_sroot[k+1])
        );
        fvrm_sqrt_cell u_flap (
            .i_clk  (i_clk),
            .i_step (5'(k)),
            .i_rem  (w_frem[k]),
            .i_root (w_froot[k]),
            .o_rem  (w_frem[k+1]),
            .o_root (w_froot[k+1])
        );
    end

    // sideband follows the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQRT_STEPS; k++) r_sq_v[k] <= 1'b0;
        end else begin
            r_sq_v[0] <= r3_v;
            for (int k = 1; k < SQRT_STEPS; k++) r_sq_v[k] <= r_sq_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_sb[0] <= r3_sb;
        for (int k = 1; k < SQRT_STEPS; k++) r_sq_sb[k] <= r_sq_sb[k-1];
    end

    // ------------------------------------------------------------------
    // stage 4: side gain product, ratio limit, CORDIC setup
    // ------------------------------------------------------------------
    t_sq_side             w_sq_o;
    logic [31:0]          w_root_s, w_root_f;
    logic signed [CW-1:0] w_px, w_py, w_fxs, w_fys;

    assign w_sq_o   = r_sq_sb[SQRT_STEPS-1];
    assign w_root_s = w_sroot[SQRT_STEPS][31:0];
    assign w_root_f = w_froot[SQRT_STEPS][31:0];
    assign w_px     = CW'(w_sq_o.fx) <<< 24;
    assign w_py     = CW'(w_sq_o.fy) <<< 24;
    assign w_fxs    = CW'({1'b0, w_sq_o.afz}) <<< 24;
    assign w_fys    = CW'({1'b0, w_root_f}) <<< 24;

    logic                 r4_v;
    logic [55:0]          r4_sp;
    logic [31:0]          r4_up;
    logic [15:0]          r4_lift;
    logic                 r4_sat, r4_zero, r4_fin;
    logic [1:0]           r4_grp;
    logic signed [CW-1:0] r4_px, r4_py, r4_fx, r4_fy;
    logic [31:0]          r4_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r_sq_v[SQRT_STEPS-1];
    end

    always_ff @(posedge i_clk) begin
        r4_sp   <= 56'(w_root_s) * 56'(r_gain);
        r4_up   <= 32'(r_ratio) * 32'(w_sq_o.lift);
        r4_lift <= w_sq_o.lift;
        r4_sat  <= w_sq_o.sat;
        r4_zero <= w_sq_o.zero_lat;
        r4_grp  <= w_sq_o.grp;
        r4_fin  <= w_sq_o.fin;
        // left half-plane turned by half a turn
        if (w_px[CW-1]) begin
            r4_px <= -w_px;
            r4_py <= -w_py;
            r4_pz <= 32'h8000_0000;
        end else begin
            r4_px <= w_px;
            r4_py <= w_py;
            r4_pz <= 32'd0;
        end
        r4_fx <= w_fxs;
        r4_fy <= w_fys;
    end

    // side throttle limits
    logic [39:0] w_s40, w_slim;
    logic [23:0] w_upper;
    t_cd_side    w_cd_in;

    assign w_s40   = r4_sp[55:16];
    assign w_upper = r4_up[31:8];
    assign w_slim  = (w_s40 > 40'(w_upper)) ? 40'(w_upper) : w_s40;

    always_comb begin
        w_cd_in.side     = (w_slim > 40'd65535) ? 16'hFFFF : w_slim[15:0];
        w_cd_in.lift     = r4_lift;
        w_cd_in.sat      = r4_sat;
        w_cd_in.zero_lat = r4_zero;
        w_cd_in.grp      = r4_grp;
        w_cd_in.fin      = r4_fin;
    end

    // ------------------------------------------------------------------
    // CORDIC cell chains (phase and flap)
    // ------------------------------------------------------------------
    logic signed [CW-1:0] w_cpx[0:CORDIC_STAGES];
    logic signed [CW-1:0] w_cpy[0:CORDIC_STAGES];
    logic [31:0]          w_cpz[0:CORDIC_STAGES];
    logic signed [CW-1:0] w_cfx[0:CORDIC_STAGES];
    logic signed [CW-1:0] w_cfy[0:CORDIC_STAGES];
    logic [31:0]          w_cfz[0:CORDIC_STAGES];
    logic                 r_cd_v [0:CORDIC_STAGES-1];
    t_cd_side             r_cd_sb[0:CORDIC_STAGES-1];

    assign w_cpx[0] = r4_px;
    assign w_cpy[0] = r4_py;
    assign w_cpz[0] = r4_pz;
    assign w_cfx[0] = r4_fx;
    assign w_cfy[0] = r4_fy;
    assign w_cfz[0] = 32'd0;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        fvrm_cordic_cell u_phase (
            .i_clk   (i_clk),
            .i_stage (STAGE_W'(k)),
            .i_x     (w_cpx[k]),
            .i_y     (w_cpy[k]),
            .i_z     (w_cpz[k]),
            .o_x     (w_cpx[k+1]),
            .o_y     (w_cpy[k+1]),
            .o_z     (w_cpz[k+1])
        );
        fvrm_cordic_cell u_flap (
            .i_clk   (i_clk),
            .i_stage (STAGE_W'(k)),
            .i_x     (w_cfx[k]),
            .i_y     (w_cfy[k]),
            .i_z     (w_cfz[k]),
            .o_x     (w_cfx[k+1]),
            .o_y     (w_cfy[k+1]),
            .o_z     (w_cfz[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORDIC_STAGES; k++) r_cd_v[k] <= 1'b0;
        end else begin
            r_cd_v[0] <= r4_v;
            for (int k = 1; k < CORDIC_STAGES; k++) r_cd_v[k] <= r_cd_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cd_sb[0] <= w_cd_in;
        for (int k = 1; k < CORDIC_STAGES; k++) r_cd_sb[k] <= r_cd_sb[k-1];
    end

    // ------------------------------------------------------------------
    // output stage: angle rounding and caps
    // ------------------------------------------------------------------
    t_cd_side    w_cd_o;
    logic [31:0] w_pr, w_fr;
    logic [15:0] w_phase, w_flap16;
    logic [14:0] w_flap;

    assign w_cd_o   = r_cd_sb[CORDIC_STAGES-1];
    assign w_pr     = w_cpz[CORDIC_STAGES] + 32'h0000_8000;
    assign w_fr     = w_cfz[CORDIC_STAGES] + 32'h0000_8000;
    assign w_phase  = w_cd_o.zero_lat ? 16'd0 : w_pr[31:16];
    assign w_flap16 = w_fr[31:16];

    always_comb begin
        priority if (w_cd_o.sat)             w_flap = 15'd0;
        else if (w_flap16 > 16'(FLAP_MAX))   w_flap = FLAP_MAX;
        else                                 w_flap = w_flap16[14:0];
    end

    logic r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= r_cd_v[CORDIC_STAGES-1];
    end

    always_ff @(posedge i_clk) begin
        o_lift_throttle  <= w_cd_o.lift;
        o_side_throttle  <= w_cd_o.side;
        o_flap_angle     <= w_flap;
        o_phase_angle    <= w_phase;
        o_group_echo     <= w_cd_o.grp;
        o_final_echo     <= w_cd_o.fin;
        o_flap_saturated <= w_cd_o.sat;
    end

    assign o_done      = r_done;
    assign o_lag_angle = r_lag;

endmodule
